@@ rtl/checksummed_frame_receiver_defines.svh @@
// ----------------------------------------------------------------------------
// checksummed frame receiver assertion macros
// Shared concurrent assertion forms, sampled on clk, quiet while in reset.
// ----------------------------------------------------------------------------
`ifndef CHECKSUMMED_FRAME_RECEIVER_DEFINES_SVH
`define CHECKSUMMED_FRAME_RECEIVER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants, codes and control bundles of the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

    // data byte limit of one frame
    localparam int DATA_MAX = 32;
    localparam int ADDR_W   = (DATA_MAX > 1) ? $clog2(DATA_MAX) : 1;

    // byte count and payload length widths
    localparam int COUNT_W = 6;
    localparam int LEN_W   = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
    localparam logic [COUNT_W-1:0] STORE_END = 6'(DATA_MAX + 2);
    localparam logic [7:0]         LEN_LIMIT = 8'(DATA_MAX);
    localparam logic [8:0]         OVERHEAD  = 9'd3;

    // frame status codes
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_SHORT    = 3'd1;
    localparam logic [2:0] STATUS_OVER_LEN = 3'd2;
    localparam logic [2:0] STATUS_SIZE     = 3'd3;
    localparam logic [2:0] STATUS_SUM      = 3'd4;

    // result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic load_status;
        logic rd_en;
        logic load_payload;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic final_taken;
        logic out_free;
        logic has_payload;
        logic replay_last;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/cfr_ram.sv @@
// ----------------------------------------------------------------------------
// cfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic                                      rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/cfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfr_ctrl
// Sequencer: byte intake, status result, then payload replay from the store.
// ----------------------------------------------------------------------------
`default_nettype none
`include "checksummed_frame_receiver_defines.svh"

module cfr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfr_pkg::dp_status_t sts,
    output cfr_pkg::ctrl_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_STATUS = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_DATA   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next       = state_reg;
        cmd.in_ready     = 1'b0;
        cmd.load_status  = 1'b0;
        cmd.rd_en        = 1'b0;
        cmd.load_payload = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.final_taken)
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_STATUS:
            begin
                if (sts.out_free)
                begin
                    cmd.load_status = 1'b1;
                    state_next      = sts.has_payload ? ST_READ : ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (sts.out_free)
                begin
                    cmd.load_payload = 1'b1;
                    state_next       = sts.replay_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `CFR_ASSERT_NOW(a_load_needs_room, cmd.load_status || cmd.load_payload, sts.out_free, "result loaded over a waiting result")
    `CFR_ASSERT_NEXT(a_final_to_status, sts.final_taken, state_reg == ST_STATUS, "final byte did not start status")
    `CFR_ASSERT_NEXT(a_read_then_data, cmd.rd_en, state_reg == ST_DATA, "store read not followed by data step")

endmodule

`default_nettype wire

@@ rtl/cfr_datapath.sv @@
// ----------------------------------------------------------------------------
// cfr_datapath
// Frame count, running sum, header capture, checks, store and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "checksummed_frame_receiver_defines.svh"

module cfr_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfr_pkg::ctrl_cmd_t  cmd,
    output cfr_pkg::dp_status_t      sts,
    input  wire logic                s_tvalid,
    input  wire logic [7:0]          s_tdata,
    input  wire logic                s_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [31:0]              m_tdata,
    output logic                     m_tuser,
    output logic                     m_tlast
);

    localparam int CW = cfr_pkg::COUNT_W;
    localparam int LW = cfr_pkg::LEN_W;
    localparam int AW = cfr_pkg::ADDR_W;

    // frame state
    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [7:0]    running_sum_reg, running_sum_next;
    logic [7:0]    command_reg, command_next;
    logic [7:0]    length_reg, length_next;

    // frame result, latched on the final byte
    logic [2:0]    res_status_reg;
    logic [7:0]    res_cmd_reg;
    logic [LW-1:0] res_len_reg;

    // replay index and output register
    logic [LW-1:0] rd_idx_reg, rd_idx_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_kind_reg;
    logic [2:0]    out_status_reg;
    logic [7:0]    out_cmd_reg;
    logic [LW-1:0] out_len_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;

    logic          take;
    logic          store_wr;
    logic [CW-1:0] store_pos;
    logic [7:0]    rd_data;
    logic [CW-1:0] total;
    logic [7:0]    frame_cmd;
    logic [2:0]    frame_status;

    assign take      = s_tvalid & cmd.in_ready;
    assign store_pos = byte_count_reg - 6'd2;
    assign store_wr  = take & ~s_tlast & (byte_count_reg >= 6'd2)
                     & (byte_count_reg < cfr_pkg::STORE_END);

    // frame counters and header capture
    always_comb
    begin
        byte_count_next  = byte_count_reg;
        running_sum_next = running_sum_reg;
        command_next     = command_reg;
        length_next      = length_reg;
        if (take)
        begin
            if (s_tlast)
            begin
                byte_count_next  = '0;
                running_sum_next = '0;
                command_next     = '0;
                length_next      = '0;
            end
            else
            begin
                if (byte_count_reg == 6'd0)
                begin
                    command_next = s_tdata;
                end
                else if (byte_count_reg == 6'd1)
                begin
                    length_next = s_tdata;
                end
                running_sum_next = running_sum_reg + s_tdata;
                if (byte_count_reg < cfr_pkg::COUNT_MAX)
                begin
                    byte_count_next = byte_count_reg + 6'd1;
                end
            end
        end
    end

    // frame checks in priority order
    always_comb
    begin
        total     = (byte_count_reg < cfr_pkg::COUNT_MAX) ? byte_count_reg + 6'd1
                                                          : cfr_pkg::COUNT_MAX;
        frame_cmd = (byte_count_reg == 6'd0) ? s_tdata : command_reg;
        if (total < 6'd3)
        begin
            frame_status = cfr_pkg::STATUS_SHORT;
        end
        else if (length_reg > cfr_pkg::LEN_LIMIT)
        begin
            frame_status = cfr_pkg::STATUS_OVER_LEN;
        end
        else if ({3'b000, total} != ({1'b0, length_reg} + cfr_pkg::OVERHEAD))
        begin
            frame_status = cfr_pkg::STATUS_SIZE;
        end
        else if (running_sum_reg != s_tdata)
        begin
            frame_status = cfr_pkg::STATUS_SUM;
        end
        else
        begin
            frame_status = cfr_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            running_sum_reg <= '0;
            command_reg     <= '0;
            length_reg      <= '0;
        end
        else
        begin
            byte_count_reg  <= byte_count_next;
            running_sum_reg <= running_sum_next;
            command_reg     <= command_next;
            length_reg      <= length_next;
        end
    end

    // result latch on the final byte
    always_ff @(posedge clk)
    begin
        if (take && s_tlast)
        begin
            res_status_reg <= frame_status;
            res_cmd_reg    <= frame_cmd;
            res_len_reg    <= (frame_status == cfr_pkg::STATUS_OK) ? length_reg[LW-1:0]
                                                                  : '0;
        end
    end

    // data byte store
    cfr_ram #(
        .WIDTH (8),
        .DEPTH (cfr_pkg::DATA_MAX)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (store_pos[AW-1:0]),
        .wr_data (s_tdata),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // status to the controller
    always_comb
    begin
        sts.final_taken = take & s_tlast;
        sts.out_free    = ~out_valid_reg | m_tready;
        sts.has_payload = (res_status_reg == cfr_pkg::STATUS_OK) && (res_len_reg != '0);
        sts.replay_last = (rd_idx_reg + 6'd1) == res_len_reg;
    end

    // replay index and output valid
    always_comb
    begin
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;
        if (cmd.load_status)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.load_payload)
        begin
            rd_idx_next = rd_idx_reg + 6'd1;
        end
        if (cmd.load_status || cmd.load_payload)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (cmd.load_status)
        begin
            out_kind_reg   <= cfr_pkg::KIND_STATUS;
            out_status_reg <= res_status_reg;
            out_cmd_reg    <= res_cmd_reg;
            out_len_reg    <= res_len_reg;
            out_byte_reg   <= '0;
            out_last_reg   <= ~sts.has_payload;
        end
        else if (cmd.load_payload)
        begin
            out_kind_reg   <= cfr_pkg::KIND_DATA;
            out_status_reg <= cfr_pkg::STATUS_OK;
            out_cmd_reg    <= res_cmd_reg;
            out_len_reg    <= res_len_reg;
            out_byte_reg   <= rd_data;
            out_last_reg   <= sts.replay_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'b0000000, out_byte_reg, out_len_reg, out_cmd_reg, out_status_reg};

    `CFR_ASSERT_NOW(a_replay_in_range, cmd.load_payload, rd_idx_reg < res_len_reg, "replay index past payload length")
    `CFR_ASSERT_NOW(a_data_is_ok, out_valid_reg && (out_kind_reg == cfr_pkg::KIND_DATA), out_status_reg == cfr_pkg::STATUS_OK, "data result without ok status")
    `CFR_ASSERT_NEXT(a_frame_cleared, take && s_tlast, (byte_count_reg == '0) && (running_sum_reg == '0), "frame state not cleared after final byte")

endmodule

`default_nettype wire

@@ rtl/checksummed_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// checksummed_frame_receiver
// Receives [command][length][data...][sum] frames, checks them, and emits a
// status result followed by the data bytes of a passing frame.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                   tuser      tlast
//  s_*      in   [7:0] rx_byte                           -          frame_end
//  m_*      out  [2:0] status [10:3] command              item_kind  last
//                [16:11] payload_length [24:17] payload_byte
//
//  Intake takes non-final bytes back to back; it pauses after a final byte.
//  The status result is registered in the status state after the final byte
//  transfer, then each data byte in a data state after a registered store read.
//  Results wait in an output register; m_tready low stalls status and replay steps.
//  Asynchronous active-low reset clears counters, sum, header and valids.
// ----------------------------------------------------------------------------
`default_nettype none

module checksummed_frame_receiver (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // status, command, payload_length, payload_byte
    output logic             m_tuser,   // item_kind
    output logic             m_tlast
);

    cfr_pkg::ctrl_cmd_t  cmd;
    cfr_pkg::dp_status_t sts;

    // sequencer
    cfr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // datapath
    cfr_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assign s_tready = cmd.in_ready;

endmodule

`default_nettype wire
